// ----- rtl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, muted while reset is held.
`define ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising edge, reset included.
`define ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/c_tok_pkg.sv -----
package c_tok_pkg;

  localparam int DEF_MAX_TOKEN_CHARS = 9;
  localparam int DEF_NUMBER_BITS     = 32;
  localparam int DEF_LINE_COUNT_BITS = 24;
  localparam int KW_COUNT            = 10 - 1 + 1;
  localparam int OUTQ_DEPTH          = 4;

  typedef enum logic [3:0] {
    CLS_KEYWORD    = 4'd0,
    CLS_IDENT      = 4'd1,
    CLS_NUMBER     = 4'd2,
    CLS_ARITH      = 4'd3,
    CLS_RELATIONAL = 4'd4,
    CLS_ASSIGN     = 4'd5,
    CLS_LOGICAL    = 4'd6,
    CLS_INVALID    = 4'd7,
    CLS_SPECIAL    = 4'd8,
    CLS_SUMMARY    = 4'd9
  } tok_class_t;

  typedef struct packed {
    logic       command;
    logic [7:0] char_code;
  } tok_in_t;

  typedef struct packed {
    logic [3:0]  token_class;
    logic [3:0]  keyword_index;
    logic [63:0] text_first_eight;
    logic [7:0]  text_ninth;
    logic [3:0]  text_length;
    logic [31:0] number_value;
    logic        number_overflow;
    logic [23:0] line_count;
    logic        last;
  } tok_result_t;

  // Up to two results per request, in order: res_a first.
  typedef struct packed {
    logic        push_a;
    logic        push_b;
    tok_result_t res_a;
    tok_result_t res_b;
  } tok_push_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } kw_hit_t;

  // Keyword text, first byte in the lowest bits, zero padded.
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h0000_0000_0072_6F66,  // for
    64'h0000_0065_6C69_6877,  // while
    64'h0000_0000_0000_6F64,  // do
    64'h0000_0000_0074_6E69,  // int
    64'h0000_0074_616F_6C66,  // float
    64'h0000_0000_7261_6863,  // char
    64'h0000_656C_6275_6F64,  // double
    64'h0000_6369_7461_7473,  // static
    64'h0000_6863_7469_7773,  // switch
    64'h0000_0000_6573_6163   // case
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd2, 4'd3, 4'd5, 4'd4, 4'd6, 4'd6, 4'd6, 4'd4
  };

  // Parallel compare against all keywords; text must be zero past len.
  function automatic kw_hit_t kw_lookup(logic [63:0] text, logic [3:0] len);
    kw_hit_t r;
    r = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (!r.hit && len == KW_LEN[i] && text == KW_TEXT[i]) begin
        r.hit = 1'b1;
        r.idx = 4'(i);
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/c_token_classifier.sv -----
// Lexical classifier for C-like source text.
// Input channel (in_valid / in_ready / in_data): one request per byte of
// text, or an end-of-text request (command = 1) that flushes the open token
// and adds a summary result carrying the newline count.
// Result channel (out_valid / out_ready / out_data): classified tokens, with
// last marking the final result caused by one request. A request gives zero,
// one or two results.
// Path: the edge that takes a request loads the input register; a later edge,
// once the result queue has room for two results, writes its results into the
// queue, whose head drives the result channel.
// Throughput: one request per clock while each gives at most one result and
// the receiver keeps up; the scan state updates once per request, and the
// four-entry result queue takes a request only with two free entries.
// Stall: when out_ready is low the head result holds, the queue fills and
// in_ready drops; nothing is lost.
// Reset (rst_n low at a clock edge): scanning returns to idle, the newline
// count and token length clear and the result queue empties.
module c_token_classifier #(
  parameter int MAX_TOKEN_CHARS = c_tok_pkg::DEF_MAX_TOKEN_CHARS,
  parameter int NUMBER_BITS     = c_tok_pkg::DEF_NUMBER_BITS,
  parameter int LINE_COUNT_BITS = c_tok_pkg::DEF_LINE_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  c_tok_pkg::tok_in_t     in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output c_tok_pkg::tok_result_t out_data
);
  import c_tok_pkg::*;

  tok_in_t   in_r;
  logic      in_vld_r;
  logic      room;
  logic      go;
  tok_push_t push;

  // Advance the held request into the scanner when the queue has space.
  assign go       = in_vld_r && room;
  assign in_ready = !in_vld_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (go) begin
      in_vld_r <= 1'b0;
    end
  end

  // Payload register: hold until replaced.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_data;
  end

  c_tok_scan #(
    .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS),
    .NUMBER_BITS     (NUMBER_BITS),
    .LINE_COUNT_BITS (LINE_COUNT_BITS)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (in_r),
    .push  (push)
  );

  // Drop results into the queue in order; the head drives the port.
  c_tok_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/c_tok_scan.sv -----
module c_tok_scan #(
  parameter int MAX_TOKEN_CHARS = c_tok_pkg::DEF_MAX_TOKEN_CHARS,
  parameter int NUMBER_BITS     = c_tok_pkg::DEF_NUMBER_BITS,
  parameter int LINE_COUNT_BITS = c_tok_pkg::DEF_LINE_COUNT_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  c_tok_pkg::tok_in_t   item,
  output c_tok_pkg::tok_push_t push
);
  import c_tok_pkg::*;

  localparam int LEN_W = $clog2(MAX_TOKEN_CHARS + 1);
  localparam int ACC_W = NUMBER_BITS + 4;
  localparam logic [NUMBER_BITS-1:0]     ACC_MAX  = '1;
  localparam logic [LINE_COUNT_BITS-1:0] LINE_MAX = '1;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;

  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_WORD    = 6'b000010,
    MODE_NUMBER  = 6'b000100,
    MODE_OPER    = 6'b001000,
    MODE_COMMENT = 6'b010000,
    MODE_CSTAR   = 6'b100000
  } scan_mode_t;

  scan_mode_t                 mode_r, mode_nxt;
  logic [7:0]                 text_r [MAX_TOKEN_CHARS];
  logic [LEN_W-1:0]           len_r, len_nxt;
  logic [NUMBER_BITS-1:0]     acc_r, acc_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [7:0]                 pend_r, pend_nxt;
  logic [LINE_COUNT_BITS-1:0] lines_r, lines_nxt;

  logic [7:0]       c;
  logic             c_digit, c_word, c_arith, c_pend;
  logic [71:0]      tok_bytes;
  kw_hit_t          kw;
  logic [ACC_W-1:0] acc_wide;
  logic             acc_sat;
  logic [3:0]       lone_cls;
  logic [3:0]       pair_cls;
  tok_result_t      word_res, num_res, lone_res, pair_res, idle_res, sum_res;
  tok_result_t      pre_res, post_res;
  logic             pre_emit, post_emit, do_idle;
  logic             wr_en, wr_first;
  logic [LEN_W-1:0] wr_pos;

  function automatic tok_result_t mk_res(logic [3:0] cls, logic [3:0] kwi,
                                         logic [71:0] txt, logic [3:0] len,
                                         logic [31:0] val, logic ovf,
                                         logic [23:0] lines);
    tok_result_t r;
    r.token_class      = cls;
    r.keyword_index    = kwi;
    r.text_first_eight = txt[63:0];
    r.text_ninth       = txt[71:64];
    r.text_length      = len;
    r.number_value     = val;
    r.number_overflow  = ovf;
    r.line_count       = lines;
    r.last             = 1'b0;
    return r;
  endfunction

  assign c       = item.char_code;
  assign c_digit = (c >= CH_0) && (c <= CH_9);
  assign c_word  = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ))
                   || (c == CH_UNDER);
  assign c_arith = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_PCT);
  assign c_pend  = (c == CH_SLASH) || (c == CH_EQ) || (c == CH_LT) || (c == CH_GT)
                   || (c == CH_AMP) || (c == CH_BAR);

  // Held token bytes, zeroed past the current length.
  always_comb begin
    tok_bytes = '0;
    for (int i = 0; i < MAX_TOKEN_CHARS; i++) begin
      if (LEN_W'(i) < len_r) tok_bytes[8*i +: 8] = text_r[i];
    end
  end

  assign kw = kw_lookup(tok_bytes[63:0], 4'(len_r));

  // Decimal step: acc * 10 + digit, saturating.
  assign acc_wide = (ACC_W'(acc_r) << 3) + (ACC_W'(acc_r) << 1) + ACC_W'(c[3:0]);
  assign acc_sat  = |acc_wide[ACC_W-1:NUMBER_BITS];

  always_comb begin
    if (pend_r == CH_EQ)                           lone_cls = CLS_ASSIGN;
    else if (pend_r == CH_LT || pend_r == CH_GT)   lone_cls = CLS_RELATIONAL;
    else if (pend_r == CH_SLASH)                   lone_cls = CLS_ARITH;
    else                                           lone_cls = CLS_INVALID;
  end

  assign pair_cls = (pend_r == CH_AMP || pend_r == CH_BAR) ? CLS_LOGICAL : CLS_RELATIONAL;

  always_comb begin
    word_res = mk_res(kw.hit ? CLS_KEYWORD : CLS_IDENT, kw.hit ? kw.idx : 4'd0,
                      tok_bytes, 4'(len_r), 32'd0, 1'b0, 24'(lines_r));
    num_res  = mk_res(CLS_NUMBER, 4'd0, tok_bytes, 4'(len_r), 32'(acc_r), ovf_r,
                      24'(lines_r));
    lone_res = mk_res(lone_cls, 4'd0, 72'(pend_r), 4'd1, 32'd0, 1'b0, 24'(lines_r));
    pair_res = mk_res(pair_cls, 4'd0, 72'({c, pend_r}), 4'd2, 32'd0, 1'b0,
                      24'(lines_r));
    idle_res = mk_res(c_arith ? CLS_ARITH : CLS_SPECIAL, 4'd0, 72'(c), 4'd1, 32'd0,
                      1'b0, 24'(lines_r));
    sum_res  = mk_res(CLS_SUMMARY, 4'd0, 72'd0, 4'd0, 32'd0, 1'b0, 24'(lines_r));
  end

  always_comb begin
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    pend_nxt  = pend_r;
    lines_nxt = lines_r;
    pre_emit  = 1'b0;
    pre_res   = word_res;
    post_emit = 1'b0;
    post_res  = idle_res;
    do_idle   = 1'b0;
    wr_en     = 1'b0;
    wr_first  = 1'b0;
    if (go) begin
      if (item.command) begin
        // Flush the open token, then report and start a fresh text.
        unique case (mode_r)
          MODE_WORD: begin
            pre_emit = 1'b1;
            pre_res  = word_res;
          end
          MODE_NUMBER: begin
            pre_emit = 1'b1;
            pre_res  = num_res;
          end
          MODE_OPER: begin
            pre_emit = 1'b1;
            pre_res  = lone_res;
          end
          default: ;
        endcase
        post_emit = 1'b1;
        post_res  = sum_res;
        mode_nxt  = MODE_IDLE;
        len_nxt   = '0;
        lines_nxt = '0;
      end else begin
        unique case (mode_r)
          MODE_COMMENT: begin
            if (c == CH_STAR) mode_nxt = MODE_CSTAR;
          end
          MODE_CSTAR: begin
            if (c == CH_SLASH)     mode_nxt = MODE_IDLE;
            else if (c != CH_STAR) mode_nxt = MODE_COMMENT;
          end
          MODE_OPER: begin
            if (pend_r == CH_SLASH && c == CH_STAR) begin
              mode_nxt = MODE_COMMENT;
            end else if ((pend_r == CH_EQ || pend_r == CH_LT || pend_r == CH_GT)
                         && c == CH_EQ) begin
              pre_emit = 1'b1;
              pre_res  = pair_res;
              mode_nxt = MODE_IDLE;
            end else if ((pend_r == CH_AMP || pend_r == CH_BAR) && c == pend_r) begin
              pre_emit = 1'b1;
              pre_res  = pair_res;
              mode_nxt = MODE_IDLE;
            end else begin
              pre_emit = 1'b1;
              pre_res  = lone_res;
              do_idle  = 1'b1;
            end
          end
          MODE_WORD: begin
            if (c_word || c_digit) begin
              wr_en = 1'b1;
              if (len_r < LEN_W'(MAX_TOKEN_CHARS)) begin
                len_nxt = len_r + LEN_W'(1);
              end else begin
                // Cut the word: emit the full piece, start the next one.
                pre_emit = 1'b1;
                pre_res  = word_res;
                wr_first = 1'b1;
                len_nxt  = LEN_W'(1);
              end
            end else begin
              pre_emit = 1'b1;
              pre_res  = word_res;
              do_idle  = 1'b1;
            end
          end
          MODE_NUMBER: begin
            if (c_digit) begin
              acc_nxt = acc_sat ? ACC_MAX : acc_wide[NUMBER_BITS-1:0];
              ovf_nxt = ovf_r | acc_sat;
              if (len_r < LEN_W'(MAX_TOKEN_CHARS)) begin
                wr_en   = 1'b1;
                len_nxt = len_r + LEN_W'(1);
              end
            end else begin
              pre_emit = 1'b1;
              pre_res  = num_res;
              do_idle  = 1'b1;
            end
          end
          MODE_IDLE: do_idle = 1'b1;
          default:   do_idle = 1'b1;
        endcase

        if (do_idle) begin
          mode_nxt = MODE_IDLE;
          if (c_digit) begin
            mode_nxt = MODE_NUMBER;
            wr_en    = 1'b1;
            wr_first = 1'b1;
            len_nxt  = LEN_W'(1);
            acc_nxt  = NUMBER_BITS'(c[3:0]);
            ovf_nxt  = 1'b0;
          end else if (c_word) begin
            mode_nxt = MODE_WORD;
            wr_en    = 1'b1;
            wr_first = 1'b1;
            len_nxt  = LEN_W'(1);
          end else if (c_arith) begin
            post_emit = 1'b1;
          end else if (c_pend) begin
            mode_nxt = MODE_OPER;
            pend_nxt = c;
          end else if (c == CH_SPACE || c == CH_TAB) begin
            // skip blanks
          end else if (c == CH_NL) begin
            if (lines_r != LINE_MAX) lines_nxt = lines_r + LINE_COUNT_BITS'(1);
          end else begin
            post_emit = 1'b1;
          end
        end
      end
    end
  end

  assign wr_pos = wr_first ? '0 : len_r;

  always_comb begin
    push        = '0;
    push.push_a = pre_emit | post_emit;
    push.push_b = pre_emit & post_emit;
    push.res_a  = pre_emit ? pre_res : post_res;
    push.res_a.last = !(pre_emit && post_emit);
    push.res_b  = post_res;
    push.res_b.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      len_r   <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      pend_r  <= '0;
      lines_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      len_r   <= len_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      pend_r  <= pend_nxt;
      lines_r <= lines_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TOKEN_CHARS; i++) begin
      if (wr_en && wr_pos == LEN_W'(i)) text_r[i] <= c;
    end
  end

endmodule

// ----- rtl/c_tok_outq.sv -----
module c_tok_outq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  c_tok_pkg::tok_push_t   push,
  output logic                   room,
  output logic                   out_valid,
  input  logic                   out_ready,
  output c_tok_pkg::tok_result_t out_data
);
  import c_tok_pkg::*;

  localparam int PTR_W = $clog2(OUTQ_DEPTH);
  localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

  tok_result_t      mem [OUTQ_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;
  logic [1:0]       n_push;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rp_r];
  assign pop       = out_valid && out_ready;
  assign n_push    = 2'(push.push_a) + 2'(push.push_b);
  // Take a new request only with space for two results.
  assign room      = (cnt_r <= CNT_W'(OUTQ_DEPTH - 2));

  assign wp_nxt  = wp_r + PTR_W'(n_push);
  assign rp_nxt  = rp_r + PTR_W'(pop);
  assign cnt_nxt = cnt_r + CNT_W'(n_push) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push_a) mem[wp_r] <= push.res_a;
    if (push.push_b) mem[wp_r + PTR_W'(1)] <= push.res_b;
  end

endmodule

// ----- rtl/c_tok_checker.sv -----
`include "assert_macros.svh"

module c_tok_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input c_tok_pkg::tok_result_t out_data
);
  import c_tok_pkg::*;

  `ASSERT_ALL(a_reset_empty, !rst_n |=> !out_valid, "result shown right after reset")
  `ASSERT_RUN(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")
  `ASSERT_RUN(a_summary_last, out_valid && out_data.token_class == CLS_SUMMARY |-> out_data.last && out_data.text_length == 4'd0, "summary not last or has text")
  `ASSERT_RUN(a_kw_index, out_valid && out_data.token_class != CLS_KEYWORD |-> out_data.keyword_index == 4'd0, "keyword index on non-keyword")

endmodule

bind c_token_classifier c_tok_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
